### rtl/polynomial_multiply_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial multiply core
// Shared forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_MULTIPLY_CORE_MACROS_SVH
`define POLYNOMIAL_MULTIPLY_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMUL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMUL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/pmul_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial multiply package
// Sizes, register codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package pmul_pkg;

    localparam int MAX_DEGREE  = 15;
    localparam int COEFF_WIDTH = 16;

    localparam int DEG_W       = 4;
    localparam int RESULT_W    = 40;
    localparam int POWER_W     = 5;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 1;

    localparam int STORE_DEPTH = MAX_DEGREE + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PROD_DEPTH  = 2 * MAX_DEGREE + 1;
    localparam int K_W         = $clog2(PROD_DEPTH);
    localparam int MUL_W       = 2 * COEFF_WIDTH;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_B = 1'b1;

    typedef struct packed {
        logic                 wr_a;
        logic                 wr_b;
        logic [IDX_W-1:0]     wr_addr;
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr_a;
        logic [IDX_W-1:0]     rd_addr_b;
        logic                 first;
        logic                 last;
        logic [POWER_W-1:0]   power;
        logic                 final_term;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_status;

    // A degree above MAX_DEGREE is used as the largest supported degree.
    function automatic logic [IDX_W-1:0] eff_degree(input logic [DEG_W-1:0] d);
        logic [IDX_W-1:0] res;
        if (int'(d) > MAX_DEGREE) begin
            res = IDX_W'(MAX_DEGREE);
        end else begin
            res = IDX_W'(d);
        end
        return res;
    endfunction

endpackage

### rtl/polynomial_multiply_core.sv
// Loading takes degree_a+degree_b+2 items at one item per cycle.
// Each product coefficient is then computed from its terms, one after another, on the
// single shared multiply-accumulate pipeline (store read, multiply, accumulate) and the
// output register; the next coefficient starts only once the previous one has left the
// block, and the next load starts only after the full product has left.
// Reset clears control state and both degrees; the coefficient stores are not cleared.
// ----------------------------------------------------------------------------
// Polynomial multiply core
// Loads two coefficient lists and emits their product by direct convolution.
// ----------------------------------------------------------------------------
`include "polynomial_multiply_core_macros.svh"

module polynomial_multiply_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [pmul_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pmul_pkg::DEG_W-1:0]              i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [pmul_pkg::COEFF_WIDTH-1:0] i_coefficient,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [pmul_pkg::RESULT_W-1:0]    o_product_coefficient,
    output logic [pmul_pkg::POWER_W-1:0]            o_power,
    output logic                                    o_last
);

    pmul_pkg::t_dp_cmd    dp_cmd;
    pmul_pkg::t_dp_status dp_status;

    pmul_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    pmul_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (dp_cmd),
        .i_coefficient         (i_coefficient),
        .o_status              (dp_status),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_product_coefficient (o_product_coefficient),
        .o_power               (o_power),
        .o_last                (o_last)
    );

    // No coefficient is taken while a result is pending.
    `PMUL_ASSERT_SAME(a_no_load_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    // A delivered result that is not the last keeps the input closed.
    `PMUL_ASSERT_NEXT(a_stall_after_mid, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_last, o_in_stall)
    // Nothing follows the last coefficient of a product.
    `PMUL_ASSERT_NEXT(a_quiet_after_last, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && o_last, !o_out_valid)

endmodule

### rtl/pmul_dp.sv
// ----------------------------------------------------------------------------
// Polynomial multiply datapath
// Coefficient stores, read/multiply/accumulate pipeline and output register.
// ----------------------------------------------------------------------------
module pmul_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pmul_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [pmul_pkg::COEFF_WIDTH-1:0] i_coefficient,
    output pmul_pkg::t_dp_status                  o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [pmul_pkg::RESULT_W-1:0]  o_product_coefficient,
    output logic [pmul_pkg::POWER_W-1:0]          o_power,
    output logic                                  o_last
);

    logic [pmul_pkg::COEFF_WIDTH-1:0] r_mem_a [pmul_pkg::STORE_DEPTH];
    logic [pmul_pkg::COEFF_WIDTH-1:0] r_mem_b [pmul_pkg::STORE_DEPTH];

    logic signed [pmul_pkg::COEFF_WIDTH-1:0] r_rd_a;
    logic signed [pmul_pkg::COEFF_WIDTH-1:0] r_rd_b;
    logic                                    r_s1_v;
    logic                                    r_s1_first;
    logic                                    r_s1_last;
    logic [pmul_pkg::POWER_W-1:0]            r_s1_power;
    logic                                    r_s1_final;

    logic signed [pmul_pkg::MUL_W-1:0]       r_prod;
    logic                                    r_s2_v;
    logic                                    r_s2_first;
    logic                                    r_s2_last;
    logic [pmul_pkg::POWER_W-1:0]            r_s2_power;
    logic                                    r_s2_final;

    logic signed [pmul_pkg::RESULT_W-1:0]    r_acc;
    logic signed [pmul_pkg::RESULT_W-1:0]    n_acc;
    logic                                    r_out_valid;
    logic                                    n_out_valid;
    logic [pmul_pkg::POWER_W-1:0]            r_out_power;
    logic                                    r_out_last;

    logic signed [63:0]                      prod_wide;
    logic signed [pmul_pkg::RESULT_W-1:0]    prod_ext;

    // Coefficient stores: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_cmd.wr_addr] <= i_coefficient;
        end
        if (i_cmd.wr_b) begin
            r_mem_b[i_cmd.wr_addr] <= i_coefficient;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem_a[i_cmd.rd_addr_a];
            r_rd_b <= r_mem_b[i_cmd.rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_power <= i_cmd.power;
        r_s1_final <= i_cmd.final_term;
        r_prod     <= r_rd_a * r_rd_b;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_power <= r_s1_power;
        r_s2_final <= r_s1_final;
        r_acc      <= n_acc;
        if (r_s2_v && r_s2_last) begin
            r_out_power <= r_s2_power;
            r_out_last  <= r_s2_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v      <= i_cmd.rd_en;
            r_s2_v      <= r_s1_v;
            r_out_valid <= n_out_valid;
        end
    end

    // The product is sign-extended, or wrapped for wide coefficients, to the result width.
    assign prod_wide = 64'(r_prod);
    assign prod_ext  = prod_wide[pmul_pkg::RESULT_W-1:0];

    always_comb begin
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_s2_v) begin
            if (r_s2_first) begin
                n_acc = prod_ext;
            end else begin
                n_acc = r_acc + prod_ext;
            end
            if (r_s2_last) begin
                n_out_valid = 1'b1;
            end
        end
    end

    assign o_status.busy         = r_s1_v | r_s2_v | r_out_valid;
    assign o_out_valid           = r_out_valid;
    assign o_product_coefficient = r_acc;
    assign o_power               = r_out_power;
    assign o_last                = r_out_last;

endmodule

### rtl/pmul_ctrl.sv
// ----------------------------------------------------------------------------
// Polynomial multiply controller
// Holds the degrees, sequences the load and the convolution terms.
// ----------------------------------------------------------------------------
module pmul_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pmul_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmul_pkg::DEG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pmul_pkg::t_dp_status               i_status,
    output pmul_pkg::t_dp_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state                           r_state;
    t_state                           n_state;
    logic [pmul_pkg::DEG_W-1:0]       r_deg_a;
    logic [pmul_pkg::DEG_W-1:0]       n_deg_a;
    logic [pmul_pkg::DEG_W-1:0]       r_deg_b;
    logic [pmul_pkg::DEG_W-1:0]       n_deg_b;
    logic [pmul_pkg::CNT_W-1:0]       r_cnt;
    logic [pmul_pkg::CNT_W-1:0]       n_cnt;
    logic [pmul_pkg::K_W-1:0]         r_k;
    logic [pmul_pkg::K_W-1:0]         n_k;
    logic [pmul_pkg::IDX_W-1:0]       r_i;
    logic [pmul_pkg::IDX_W-1:0]       n_i;

    logic [pmul_pkg::IDX_W-1:0]       da;
    logic [pmul_pkg::IDX_W-1:0]       db;
    logic [pmul_pkg::IDX_W:0]         na;
    logic [pmul_pkg::IDX_W+1:0]       total;
    logic [pmul_pkg::CNT_W-1:0]       cnt_inc;
    logic [pmul_pkg::CNT_W-1:0]       cnt_b;
    logic                             accept;
    logic                             cfg_wr;
    logic [pmul_pkg::K_W-1:0]         k_inc;
    logic [pmul_pkg::K_W-1:0]         j_full;
    logic [pmul_pkg::IDX_W-1:0]       lo;
    logic [pmul_pkg::IDX_W-1:0]       lo_next;
    logic [pmul_pkg::IDX_W-1:0]       hi;
    logic                             final_k;

    assign da      = pmul_pkg::eff_degree(r_deg_a);
    assign db      = pmul_pkg::eff_degree(r_deg_b);
    assign na      = {1'b0, da} + 1'b1;
    assign total   = (pmul_pkg::IDX_W+2)'(na) + (pmul_pkg::IDX_W+2)'(db) + 1'b1;
    assign cnt_inc = r_cnt + 1'b1;
    assign cnt_b   = r_cnt - pmul_pkg::CNT_W'(na);

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign o_in_stall  = (r_state != S_LOAD);
    assign accept      = i_in_valid && !o_in_stall;

    // Term range for product coefficient k: i from max(0, k-db) to min(k, da).
    assign k_inc   = r_k + 1'b1;
    assign j_full  = r_k - pmul_pkg::K_W'(r_i);
    assign lo      = (int'(r_k) > int'(db)) ? pmul_pkg::IDX_W'(r_k - pmul_pkg::K_W'(db)) : '0;
    assign lo_next = (int'(k_inc) > int'(db)) ?
                     pmul_pkg::IDX_W'(k_inc - pmul_pkg::K_W'(db)) : '0;
    assign hi      = (int'(r_k) < int'(da)) ? pmul_pkg::IDX_W'(r_k) : da;
    assign final_k = (int'(r_k) == int'(da) + int'(db));

    always_comb begin
        n_state = r_state;
        n_deg_a = r_deg_a;
        n_deg_b = r_deg_b;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_i     = r_i;

        o_cmd            = '0;
        o_cmd.rd_addr_a  = r_i;
        o_cmd.rd_addr_b  = pmul_pkg::IDX_W'(j_full);
        o_cmd.first      = (r_i == lo);
        o_cmd.last       = (r_i == hi);
        o_cmd.power      = pmul_pkg::POWER_W'(r_k);
        o_cmd.final_term = final_k;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (int'(r_cnt) < int'(na)) begin
                        o_cmd.wr_a    = 1'b1;
                        o_cmd.wr_addr = pmul_pkg::IDX_W'(r_cnt);
                    end else begin
                        o_cmd.wr_b    = 1'b1;
                        o_cmd.wr_addr = pmul_pkg::IDX_W'(cnt_b);
                    end
                    if (int'(cnt_inc) == int'(total)) begin
                        n_cnt   = '0;
                        n_k     = '0;
                        n_i     = '0;
                        n_state = S_ISSUE;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                if (r_i == hi) begin
                    n_state = S_DRAIN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_DRAIN: begin
                // The next coefficient starts only once this one has left the block.
                if (!i_status.busy) begin
                    if (final_k) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = k_inc;
                        n_i     = lo_next;
                        n_state = S_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (cfg_wr) begin
            unique case (i_cfg_index)
                pmul_pkg::CFG_DEGREE_A: n_deg_a = i_cfg_data;
                pmul_pkg::CFG_DEGREE_B: n_deg_b = i_cfg_data;
                default: begin
                    n_deg_a = r_deg_a;
                end
            endcase
            // A register write drops any partial load.
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_deg_a <= '0;
            r_deg_b <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_deg_a <= n_deg_a;
            r_deg_b <= n_deg_b;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_i     <= n_i;
        end
    end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Polynomial multiply core testbench
// Loads coefficient lists under several degree settings, predicts every
// product coefficient by direct convolution and checks each output item
// against the oldest prediction, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS  = 256;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 60;
    localparam int TIMEOUT       = 10_000_000;

    typedef struct {
        logic signed [pmul_pkg::RESULT_W-1:0] coeff;
        logic [pmul_pkg::POWER_W-1:0]         power;
        logic                                 last;
    } t_product_term;

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_cfg_valid = 1'b0;
    logic                                    o_cfg_ready;
    logic [pmul_pkg::CFG_IDX_W-1:0]          i_cfg_index = pmul_pkg::CFG_DEGREE_A;
    logic [pmul_pkg::DEG_W-1:0]              i_cfg_data = '0;
    logic                                    i_in_valid = 1'b0;
    logic                                    o_in_stall;
    logic signed [pmul_pkg::COEFF_WIDTH-1:0] i_coefficient = '0;
    logic                                    o_out_valid;
    logic                                    i_out_stall = 1'b0;
    logic signed [pmul_pkg::RESULT_W-1:0]    o_product_coefficient;
    logic [pmul_pkg::POWER_W-1:0]            o_power;
    logic                                    o_last;

    // Local copy of the block's configuration and load state.
    logic [pmul_pkg::DEG_W-1:0]              degree_a_now = '0;
    logic [pmul_pkg::DEG_W-1:0]              degree_b_now = '0;
    logic signed [pmul_pkg::COEFF_WIDTH-1:0] first_coeffs [pmul_pkg::STORE_DEPTH];
    logic signed [pmul_pkg::COEFF_WIDTH-1:0] second_coeffs [pmul_pkg::STORE_DEPTH];
    int                                      coeffs_loaded = 0;

    t_product_term product_terms_due [$];
    int            error_count = 0;

    int sender_gap_pct = 0;
    int sender_gap_max = 4;
    int burst_left = 0;
    int stall_pct = 0;
    int stall_run_max = 4;
    int stall_left = 0;

    polynomial_multiply_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_coefficient         (i_coefficient),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_product_coefficient (o_product_coefficient),
        .o_power               (o_power),
        .o_last                (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stall pattern: each decision holds for a random number of cycles.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            stall_left  <= $urandom_range(stall_run_max);
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin : check_products
        t_product_term want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (product_terms_due.size() == 0) begin
                note_error($sformatf("unexpected item: coeff %0d power %0d last %0b",
                                     o_product_coefficient, o_power, o_last));
            end else begin
                want = product_terms_due.pop_front();
                if (o_product_coefficient !== want.coeff || o_power !== want.power ||
                    o_last !== want.last) begin
                    note_error($sformatf(
                        "mismatch: expected coeff %0d power %0d last %0b, got %0d %0d %0b",
                        want.coeff, want.power, want.last,
                        o_product_coefficient, o_power, o_last));
                end
            end
        end
    end

    // Sends one coefficient and, once it is taken, updates the local load state.
    // The item that completes the load queues the whole convolution.
    task automatic send_coefficient(input logic signed [pmul_pkg::COEFF_WIDTH-1:0] c);
        int                                   na;
        int                                   total;
        int                                   gap;
        logic signed [pmul_pkg::MUL_W-1:0]    term;
        logic signed [pmul_pkg::RESULT_W-1:0] acc [pmul_pkg::PROD_DEPTH];
        t_product_term                        t;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(99) < sender_gap_pct) begin
                gap = $urandom_range(1, sender_gap_max);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_coefficient <= c;
        do @(posedge i_clk); while (o_in_stall);

        na    = degree_a_now + 1;
        total = na + degree_b_now + 1;
        if (coeffs_loaded < na) begin
            first_coeffs[coeffs_loaded] = c;
        end else begin
            second_coeffs[coeffs_loaded - na] = c;
        end
        coeffs_loaded++;
        if (coeffs_loaded == total) begin
            coeffs_loaded = 0;
            for (int k = 0; k < pmul_pkg::PROD_DEPTH; k++) begin
                acc[k] = '0;
            end
            for (int i = 0; i <= degree_a_now; i++) begin
                for (int j = 0; j <= degree_b_now; j++) begin
                    term = first_coeffs[i] * second_coeffs[j];
                    acc[i + j] += term;
                end
            end
            for (int k = 0; k < total - 1; k++) begin
                t.coeff = acc[k];
                t.power = pmul_pkg::POWER_W'(k);
                t.last  = (k == total - 2);
                product_terms_due.push_back(t);
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (product_terms_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write valid high so that a second write can follow directly.
    task automatic write_register(input logic [pmul_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pmul_pkg::DEG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pmul_pkg::CFG_DEGREE_A) begin
            degree_a_now = value;
        end else begin
            degree_b_now = value;
        end
        // Any write drops a partial load.
        coeffs_loaded = 0;
    endtask

    task automatic configure(input bit set_a, input logic [pmul_pkg::DEG_W-1:0] deg_a,
                             input bit set_b, input logic [pmul_pkg::DEG_W-1:0] deg_b);
        wait_idle();
        if (set_a) begin
            write_register(pmul_pkg::CFG_DEGREE_A, deg_a);
        end
        if (set_b) begin
            write_register(pmul_pkg::CFG_DEGREE_B, deg_b);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Both degrees are zero out of reset, so pairs of items give one product each.
    task automatic test_reset_degrees();
        send_coefficient(16'sh0100);
        send_coefficient(16'sh0200);
        send_coefficient(16'sh8000);
        send_coefficient(16'sh8000);
        send_coefficient(16'sh7fff);
        send_coefficient(16'sh8000);
    endtask

    task automatic test_unequal_degrees();
        stall_pct = 40;
        configure(1'b1, 4'd3, 1'b1, 4'd0);
        send_coefficient(16'sh0000);
        send_coefficient(16'shffff);
        send_coefficient(16'sh0001);
        send_coefficient(16'sh7fff);
        send_coefficient(16'sh8000);
        configure(1'b1, 4'd0, 1'b1, 4'd2);
        send_coefficient(16'sh7fff);
        send_coefficient(16'sh7fff);
        send_coefficient(16'sh8000);
        send_coefficient(16'sh0180);
    endtask

    // A degree write in the middle of a load restarts it at the first coefficient.
    task automatic test_dropped_load();
        sender_gap_pct = 50;
        configure(1'b1, 4'd2, 1'b1, 4'd1);
        send_coefficient(16'sh1234);
        send_coefficient(16'shedcb);
        send_coefficient(16'sh7fff);
        configure(1'b0, 4'd0, 1'b1, 4'd2);
        send_coefficient(16'sh0100);
        send_coefficient(16'shff00);
        send_coefficient(16'sh0080);
        send_coefficient(16'sh8000);
        send_coefficient(16'sh0003);
        send_coefficient(16'shfffd);
    endtask

    task automatic test_random_products();
        int                                      sent;
        int                                      phase;
        int                                      total;
        int                                      count;
        logic [pmul_pkg::DEG_W-1:0]              deg_a;
        logic [pmul_pkg::DEG_W-1:0]              deg_b;
        logic signed [pmul_pkg::COEFF_WIDTH-1:0] c;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(2))
                0: sender_gap_pct = 0;
                1: sender_gap_pct = 30;
                default: sender_gap_pct = 80;
            endcase
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 60;
            endcase
            sender_gap_max = $urandom_range(1, 6);
            stall_run_max  = $urandom_range(0, 8);

            // The four corner settings come first, then mostly small degrees.
            if (phase < 4) begin
                deg_a = phase[0] ? 4'd15 : 4'd0;
                deg_b = phase[1] ? 4'd15 : 4'd0;
            end else if ($urandom_range(9) == 0) begin
                deg_a = pmul_pkg::DEG_W'($urandom_range(15));
                deg_b = pmul_pkg::DEG_W'($urandom_range(15));
            end else begin
                deg_a = pmul_pkg::DEG_W'($urandom_range(4));
                deg_b = pmul_pkg::DEG_W'($urandom_range(4));
            end
            if (phase < 4 || $urandom_range(3) != 0) begin
                configure(1'b1, deg_a, 1'b1, deg_b);
            end
            total = degree_a_now + degree_b_now + 2;
            // Now and then a load is cut short; the next write drops it, or else
            // the following items continue it.
            if ($urandom_range(9) == 0) begin
                count = $urandom_range(1, total - 1);
            end else begin
                count = total;
            end
            for (int n = 0; n < count; n++) begin
                case ($urandom_range(9))
                    0: c = 16'sh8000;
                    1: c = 16'sh7fff;
                    2: c = 16'sh0000;
                    default: c = pmul_pkg::COEFF_WIDTH'($urandom);
                endcase
                send_coefficient(c);
            end
            sent += count;
            phase++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_degrees();
        test_unequal_degrees();
        test_dropped_load();
        test_random_products();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/pmul_pkg.sv
rtl/pmul_dp.sv
rtl/pmul_ctrl.sv
rtl/polynomial_multiply_core.sv
sim/testbench.sv
